// ===== rtl/streaming_pattern_matcher_defines.svh =====
// Assertion macros for the streaming pattern matcher.
// Included by the top level; relies on i_clk and i_rst_n being in scope.
`ifndef STREAMING_PATTERN_MATCHER_DEFINES_SVH
`define STREAMING_PATTERN_MATCHER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SPM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spm_pkg.sv =====
// Shared types and constants for the streaming pattern matcher.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package spm_pkg;

    localparam int SPM_MAX_PATTERN = 16;
    localparam int PATTERN_BYTES   = 16;
    localparam int LEN_W           = 5;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int INDEX_W         = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

    typedef logic [PATTERN_BYTES-1:0][7:0] t_pattern;

    typedef struct packed {
        logic             shift;
        logic             clear;
        logic [LEN_W-1:0] len;
    } t_cell_ctrl;

    typedef struct packed {
        logic [INDEX_W-1:0] byte_index;
        logic [INDEX_W-1:0] match_start;
        logic               match_found;
    } t_result;

endpackage

// ===== rtl/spm_cell.sv =====
// One window cell: holds one recent text byte and its valid flag, and compares
// the incoming byte with the pattern byte that lines up with it. Uses spm_pkg.
`timescale 1ns / 1ps

module spm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spm_pkg::t_cell_ctrl   i_ctrl,
    input  spm_pkg::t_pattern     i_pattern,
    input  logic [7:0]            i_byte,
    input  logic                  i_valid,
    output logic [7:0]            o_byte,
    output logic                  o_valid,
    output logic                  o_hit
);
    import spm_pkg::*;

    logic [7:0]       r_byte;
    logic             r_valid;
    logic [7:0]       n_byte;
    logic             n_valid;
    logic [LEN_W-1:0] w_sel;
    logic             w_in_use;

    always_comb begin
        n_byte  = i_ctrl.clear ? 8'd0 : i_byte;
        n_valid = i_ctrl.clear ? 1'b0 : i_valid;
    end

    assign w_sel    = i_ctrl.len - LEN_W'(CELL_IDX + 1);
    assign w_in_use = LEN_W'(CELL_IDX) < i_ctrl.len;
    assign o_hit    = !w_in_use || (n_valid && (n_byte == i_pattern[w_sel[3:0]]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

// ===== rtl/spm_skid.sv =====
// Two-entry output buffer for result transfers, so that input transfers go on
// while a result waits downstream. Uses spm_pkg for the result type.
`timescale 1ns / 1ps

module spm_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  spm_pkg::t_result  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output spm_pkg::t_result  o_data
);
    import spm_pkg::*;

    logic    r_valid;
    logic    r_skid_valid;
    t_result r_data;
    t_result r_skid_data;
    logic    n_valid;
    logic    n_skid_valid;
    t_result n_data;
    t_result n_skid_data;

    always_comb begin
        n_valid      = r_valid;
        n_skid_valid = r_skid_valid;
        n_data       = r_data;
        n_skid_data  = r_skid_data;
        if (!r_valid || i_ready) begin
            if (r_skid_valid) begin
                n_valid      = 1'b1;
                n_data       = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_valid = i_valid;
                n_data  = i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            n_skid_valid = 1'b1;
            n_skid_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data      <= n_data;
        r_skid_data <= n_skid_data;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/streaming_pattern_matcher.sv =====
// Top level of the streaming pattern matcher: configuration registers, byte
// counter, the row of spm_cell window cells and the spm_skid output buffer.
`timescale 1ns / 1ps
`include "streaming_pattern_matcher_defines.svh"

// The block takes one text byte per clock while s_axis_tready is high, returns
// one registered result per byte and reports every occurrence of the
// pattern (overlaps included) on the byte where it ends. The rate is set by
// the row of MAX_PATTERN cells, which shift the recent bytes along and compare
// all of them with the pattern in the same cycle. A two-entry output buffer
// lets input transfers continue while one result waits. There is no clearing
// pass after reset, and configuration writes are accepted in every cycle.
module streaming_pattern_matcher #(
    parameter int MAX_PATTERN = spm_pkg::SPM_MAX_PATTERN
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // text_byte [7:0]
    input  logic [7:0]                       s_axis_tdata,
    // text_start [0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // match_start [31:0], byte_index [63:32]
    output logic [2*spm_pkg::INDEX_W-1:0]    m_axis_tdata,
    // match_found [0]
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [spm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [spm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import spm_pkg::*;

    logic [LEN_W-1:0]       r_pattern_len;
    t_pattern               r_pattern;
    logic [INDEX_W-1:0]     r_bytes_seen;
    logic [LEN_W-1:0]       w_len;
    logic                   w_accept;
    logic [INDEX_W-1:0]     w_index;
    logic [MAX_PATTERN-1:0] w_hit;
    logic [MAX_PATTERN-1:0] w_cell_valid;
    logic [7:0]             w_cell_byte [MAX_PATTERN];
    logic                   w_found;
    t_result                w_result;
    t_result                w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len <= LEN_W'(1);
            r_pattern     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PATTERN_LENGTH: r_pattern_len   <= i_cfg_data[LEN_W-1:0];
                REG_PATTERN_LOW:    r_pattern[7:0]  <= i_cfg_data;
                REG_PATTERN_HIGH:   r_pattern[15:8] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_len    = (r_pattern_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                            : r_pattern_len;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_index  = s_axis_tuser ? '0 : r_bytes_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
        end else if (w_accept) begin
            r_bytes_seen <= w_index + INDEX_W'(1);
        end
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        t_cell_ctrl w_ctrl;
        logic [7:0] w_in_byte;
        logic       w_in_valid;

        assign w_ctrl.shift = w_accept;
        assign w_ctrl.len   = w_len;

        if (g == 0) begin : g_head
            assign w_ctrl.clear = 1'b0;
            assign w_in_byte    = s_axis_tdata;
            assign w_in_valid   = 1'b1;
        end else begin : g_body
            assign w_ctrl.clear = s_axis_tuser;
            assign w_in_byte    = w_cell_byte[g-1];
            assign w_in_valid   = w_cell_valid[g-1];
        end

        spm_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_pattern (r_pattern),
            .i_byte    (w_in_byte),
            .i_valid   (w_in_valid),
            .o_byte    (w_cell_byte[g]),
            .o_valid   (w_cell_valid[g]),
            .o_hit     (w_hit[g])
        );
    end

    assign w_found = (w_len != '0) && (&w_hit);

    always_comb begin
        w_result.match_found = w_found;
        w_result.byte_index  = w_index;
        w_result.match_start = w_found
            ? (w_index - {{(INDEX_W-LEN_W){1'b0}}, w_len} + INDEX_W'(1))
            : '0;
    end

    spm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .o_ready (s_axis_tready),
        .i_data  (w_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {w_out.byte_index, w_out.match_start};
    assign m_axis_tuser = w_out.match_found;

    `SPM_ASSERT_SAME(a_no_match_zero_start, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:0] == '0, "match_start is not zero on a result without a match")
    `SPM_ASSERT_NEXT(a_start_restarts_count, w_accept && s_axis_tuser, r_bytes_seen == INDEX_W'(1), "byte count did not restart at a text start")
    `SPM_ASSERT_NEXT(a_head_cell_loaded, w_accept, w_cell_valid[0] && (w_cell_byte[0] == $past(s_axis_tdata)), "head cell does not hold the byte just transferred")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for streaming_pattern_matcher: drives text bytes and
// pattern settings, predicts every result and compares it field by field.
// Depends on spm_pkg and the streaming_pattern_matcher RTL only.
`timescale 1ns / 1ps

module tb_top;
    import spm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [7:0] value;
        logic       first;
    } t_text_byte;

    typedef struct {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_reg_write;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata = '0;
    logic                        s_axis_tuser = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [2*INDEX_W-1:0]        m_axis_tdata;
    logic                        m_axis_tuser;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_INDEX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    t_text_byte text_queue[$];
    t_reg_write reg_queue[$];
    t_result    expected_results[$];

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int error_count = 0;

    // Predictor state: pattern settings and the recent-byte window of the text.
    logic [4:0]             pat_len;
    logic [63:0]            pat_low;
    logic [63:0]            pat_high;
    logic [15:0][7:0]       window;
    logic [INDEX_W-1:0]     text_count;
    int                     window_fill;

    streaming_pattern_matcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_result predict_match(input logic [7:0] value, input logic first);
        t_result          r;
        int               len;
        logic             hit;
        logic [127:0]     pat;
        logic [INDEX_W-1:0] idx;
        if (first) begin
            window = '0;
            text_count = '0;
            window_fill = 0;
        end
        idx = text_count;
        window = {window[14:0], value};
        if (window_fill < SPM_MAX_PATTERN) window_fill++;
        text_count = text_count + INDEX_W'(1);
        len = pat_len;
        if (len > SPM_MAX_PATTERN) len = SPM_MAX_PATTERN;
        pat = {pat_high, pat_low};
        hit = 1'b0;
        if (len > 0 && window_fill >= len) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (window[len - 1 - i] != pat[8*i +: 8]) hit = 1'b0;
            end
        end
        r.match_found = hit;
        r.match_start = hit ? idx - INDEX_W'(len - 1) : '0;
        r.byte_index  = idx;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin : drive_text
        t_text_byte item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_match(s_axis_tdata, s_axis_tuser));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (text_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    item = text_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.value;
                    s_axis_tuser  <= item.first;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : drive_regs
        t_reg_write w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PATTERN_LENGTH: pat_len  <= i_cfg_data[4:0];
                    REG_PATTERN_LOW:    pat_low  <= i_cfg_data;
                    REG_PATTERN_HIGH:   pat_high <= i_cfg_data;
                    default: ;
                endcase
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_queue.size() > 0) begin
                    w = reg_queue.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= w.index;
                    i_cfg_data  <= w.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, byte_index", m_axis_tdata[63:32], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.match_found)
                        report_mismatch("match_found", m_axis_tuser, want.match_found);
                    if (m_axis_tdata[31:0] !== want.match_start)
                        report_mismatch("match_start", m_axis_tdata[31:0], want.match_start);
                    if (m_axis_tdata[63:32] !== want.byte_index)
                        report_mismatch("byte_index", m_axis_tdata[63:32], want.byte_index);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic add_text(input logic [7:0] value, input logic first);
        t_text_byte item;
        item.value = value;
        item.first = first;
        text_queue.push_back(item);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (text_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        t_reg_write w;
        w.index = index;
        w.data  = data;
        reg_queue.push_back(w);
        do @(negedge i_clk);
        while (reg_queue.size() != 0 || i_cfg_valid);
    endtask

    initial begin : stimulus
        int          lens[9];
        logic [7:0]  alphabet[3];
        logic [7:0]  pat[16];
        logic [63:0] word;
        int          eff;
        int          count;
        lens = '{2, 16, 5, 1, 31, 3, 17, 8, 0};
        pat_len = 5'd1;
        pat_low = '0;
        pat_high = '0;
        window = '0;
        text_count = '0;
        window_fill = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 21;
        receiver_idle_pct = 71;
        // Bytes before any start flag belong to the text that begins at reset.
        add_text(8'h00, 1'b0);
        add_text(8'hFF, 1'b0);
        add_text(8'h00, 1'b0);
        wait_drained();
        // The new pattern is compared against the bytes already in the window.
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_PATTERN_LOW, 64'h616261);
        add_text(8'h62, 1'b0);
        add_text(8'h61, 1'b0);
        add_text(8'h61, 1'b1);
        add_text(8'h62, 1'b0);
        add_text(8'h61, 1'b0);
        add_text(8'h62, 1'b0);
        add_text(8'h61, 1'b0);
        add_text(8'h61, 1'b1);
        add_text(8'h62, 1'b0);
        wait_drained();
        write_reg(REG_PATTERN_LOW, '1);
        write_reg(REG_PATTERN_HIGH, '1);
        write_reg(REG_PATTERN_LENGTH, 64'd16);
        for (int i = 0; i < 16; i++) add_text(8'hFF, i == 0);
        wait_drained();
        // A zero length never matches; the upper data bits are not stored.
        write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        add_text(8'hFF, 1'b0);
        add_text(8'hFF, 1'b0);
        wait_drained();
        write_reg(REG_PATTERN_LENGTH, 64'd31);
        add_text(8'hFF, 1'b0);
        wait_drained();
        write_reg(REG_SPARE, {$urandom, $urandom});
        add_text(8'hFF, 1'b0);
        wait_drained();

        for (int p = 0; p < 9; p++) begin
            case (p / 3)
                0: begin
                    sender_idle_pct = 21;
                    receiver_idle_pct = 71;
                end
                1: begin
                    sender_idle_pct = 71;
                    receiver_idle_pct = 21;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 3; k++) alphabet[k] = 8'($urandom_range(255));
            eff = (lens[p] > SPM_MAX_PATTERN) ? SPM_MAX_PATTERN : lens[p];
            for (int k = 0; k < 16; k++) begin
                pat[k] = (k < eff) ? alphabet[$urandom_range(2)] : 8'($urandom_range(255));
            end
            word = {$urandom, $urandom};
            word[4:0] = 5'(lens[p]);
            write_reg(REG_PATTERN_LENGTH, word);
            for (int k = 0; k < 8; k++) word[8*k +: 8] = pat[k];
            write_reg(REG_PATTERN_LOW, word);
            for (int k = 0; k < 8; k++) word[8*k +: 8] = pat[k + 8];
            write_reg(REG_PATTERN_HIGH, word);
            if (eff == 0) eff = 4;
            count = 0;
            while (count < 185) begin
                if (p == 4 && count >= 90 && count < 95) begin
                    wait_drained();
                    count = 95;
                end
                if ($urandom_range(99) < 35) begin
                    for (int k = 0; k < eff; k++) begin
                        add_text(($urandom_range(9) == 0) ? alphabet[$urandom_range(2)] : pat[k],
                                 k == 0 && $urandom_range(19) == 0);
                        count++;
                    end
                end else if ($urandom_range(99) < 85) begin
                    add_text(alphabet[$urandom_range(2)], $urandom_range(39) == 0);
                    count++;
                end else begin
                    add_text(8'($urandom_range(255)), $urandom_range(39) == 0);
                    count++;
                end
            end
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #2_400_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
